### hdl/rstim_pkg.sv
package rstim_pkg;

  localparam int MAX_MAP      = 16383;
  localparam int FRAC_BITS    = 8;
  localparam int COEF_FRAC    = 22;
  localparam int OUT_SHIFT    = COEF_FRAC - FRAC_BITS;
  localparam int CORDIC_STEPS = 30;

  // CORDIC start vector and angle folding constants, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [35:0] PI_Q30      = 36'sh0C90FDAA0;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sh06487ED50;

  typedef enum logic [2:0] {
    REG_ROT_ANGLE   = 3'd0,
    REG_SCALE_HORIZ = 3'd1,
    REG_SCALE_VERT  = 3'd2,
    REG_SHIFT_HORIZ = 3'd3,
    REG_SHIFT_VERT  = 3'd4,
    REG_SOURCE_ROWS = 3'd5,
    REG_SOURCE_COLS = 3'd6
  } reg_idx_t;

  // Derived mapping state handed to the pixel pipeline
  typedef struct packed {
    logic [31:0] coeff_a;
    logic [31:0] coeff_b;
    logic [31:0] coeff_c;
    logic [31:0] coeff_d;
    logic [39:0] off_first;
    logic [39:0] off_second;
    logic [13:0] size_rows;
    logic [13:0] size_cols;
    logic        size_sat;
    logic [11:0] half_rows;
    logic [11:0] half_cols;
  } derived_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      5'd24: r = 30'h0000003F;
      5'd25: r = 30'h0000001F;
      5'd26: r = 30'h0000000F;
      5'd27: r = 30'h00000008;
      5'd28: r = 30'h00000004;
      5'd29: r = 30'h00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/rstim_derive.sv
module rstim_derive
  import rstim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output logic        busy,
  output derived_t    dv
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_FOLD, S_ROT, S_TRIG, S_DLOAD, S_DIV, S_MUL
  } state_t;

  state_t state_r;

  logic signed [16:0] angle_r;
  logic [15:0]        scale_h_r, scale_v_r;
  logic signed [15:0] shift_h_r, shift_v_r;
  logic [12:0]        rows_r, cols_r;

  logic signed [35:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic               neg_r;
  logic [4:0]         cnt_r;
  logic signed [21:0] c_r, s_r;
  logic [1:0]         j_r;
  logic [15:0]        rem_r;
  logic [30:0]        quo_r;
  logic               dneg_r;
  logic [3:0]         k_r;
  logic               ph_r;
  logic signed [49:0] prod_r, acc_r;
  logic [13:0]        er_r, ec_r;
  logic               sat_r;

  logic [31:0] ca_r, cb_r, cc_r, cd_r;
  logic [39:0] off1_r, off2_r;
  logic [13:0] map_rows_r, map_cols_r;

  logic [15:0]        sx_eff, sy_eff, dvs;
  logic signed [33:0] dx, dy;
  logic signed [35:0] at;
  logic signed [21:0] cx, sx_t, num, mag, ac, as_v;
  logic [16:0]        trial, diff;
  logic               ge;
  logic [15:0]        rem_nxt;
  logic [30:0]        quo_nxt;
  logic [31:0]        coeff_res;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod, sum;
  logic [21:0]        msz;

  function automatic logic signed [21:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [21:0] o;
    r = (v + 34'sd512) >>> 10;
    if (r > 34'sd1048576) o = 22'sd1048576;
    else if (r < -34'sd1048576) o = -22'sd1048576;
    else o = r[21:0];
    return o;
  endfunction

  assign sx_eff = (scale_h_r == 16'd0) ? 16'd1 : scale_h_r;
  assign sy_eff = (scale_v_r == 16'd0) ? 16'd1 : scale_v_r;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = $signed({6'b0, atan_lut(cnt_r)});

  assign cx   = clamp_unit(x_r);
  assign sx_t = clamp_unit(y_r);

  always_comb begin
    unique case (j_r)
      2'd0:    num = c_r;
      2'd1:    num = s_r;
      2'd2:    num = -s_r;
      default: num = c_r;
    endcase
  end

  assign mag  = (num < 0) ? -num : num;
  assign dvs  = j_r[0] ? sy_eff : sx_eff;
  assign ac   = (c_r < 0) ? -c_r : c_r;
  assign as_v = (s_r < 0) ? -s_r : s_r;

  // one restoring step per cycle
  assign trial     = {rem_r, quo_r[30]};
  assign diff      = trial - {1'b0, dvs};
  assign ge        = (trial >= {1'b0, dvs});
  assign rem_nxt   = ge ? diff[15:0] : trial[15:0];
  assign quo_nxt   = {quo_r[29:0], ge};
  assign coeff_res = dneg_r ? (32'd0 - {1'b0, quo_nxt}) : {1'b0, quo_nxt};

  always_comb begin
    unique case (k_r)
      4'd0:    begin mul_a = 33'($signed(ca_r)); mul_b = 17'(shift_v_r); end
      4'd1:    begin mul_a = 33'($signed(cb_r)); mul_b = 17'(shift_h_r); end
      4'd2:    begin mul_a = 33'($signed(cc_r)); mul_b = 17'(shift_v_r); end
      4'd3:    begin mul_a = 33'($signed(cd_r)); mul_b = 17'(shift_h_r); end
      4'd4:    begin mul_a = {12'b0, as_v[20:0]}; mul_b = {4'b0, cols_r}; end
      4'd5:    begin mul_a = {12'b0, ac[20:0]};   mul_b = {4'b0, rows_r}; end
      4'd6:    begin mul_a = {12'b0, ac[20:0]};   mul_b = {4'b0, cols_r}; end
      4'd7:    begin mul_a = {12'b0, as_v[20:0]}; mul_b = {4'b0, rows_r}; end
      4'd8:    begin mul_a = {19'b0, er_r};       mul_b = {1'b0, sx_eff}; end
      default: begin mul_a = {19'b0, ec_r};       mul_b = {1'b0, sy_eff}; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = ((k_r < 4'd8 && k_r[0]) ? acc_r : 50'sd0) + prod_r;
  assign msz  = sum[29:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      angle_r    <= '0;
      scale_h_r  <= 16'd256;
      scale_v_r  <= 16'd256;
      shift_h_r  <= '0;
      shift_v_r  <= '0;
      rows_r     <= 13'd512;
      cols_r     <= 13'd512;
      ca_r       <= '0;
      cb_r       <= '0;
      cc_r       <= '0;
      cd_r       <= '0;
      off1_r     <= '0;
      off2_r     <= '0;
      map_rows_r <= '0;
      map_cols_r <= '0;
      sat_r      <= 1'b0;
      cnt_r      <= '0;
      j_r        <= '0;
      k_r        <= '0;
      ph_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_ROT_ANGLE:   angle_r   <= $signed(cfg_data);
              REG_SCALE_HORIZ: scale_h_r <= cfg_data[15:0];
              REG_SCALE_VERT:  scale_v_r <= cfg_data[15:0];
              REG_SHIFT_HORIZ: shift_h_r <= $signed(cfg_data[15:0]);
              REG_SHIFT_VERT:  shift_v_r <= $signed(cfg_data[15:0]);
              REG_SOURCE_ROWS: rows_r    <= cfg_data[12:0];
              REG_SOURCE_COLS: cols_r    <= cfg_data[12:0];
              default: ;
            endcase
            // drop an unknown index without recomputing
            if (cfg_index <= REG_SOURCE_COLS) state_r <= S_INIT;
          end
        end
        S_INIT: begin
          z_r     <= 36'(angle_r) <<< 17;
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          neg_r   <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (z_r > HALF_PI_Q30) begin
            z_r   <= z_r - PI_Q30;
            neg_r <= ~neg_r;
          end else if (z_r < -HALF_PI_Q30) begin
            z_r   <= z_r + PI_Q30;
            neg_r <= ~neg_r;
          end
          if (cnt_r == 5'd3) begin
            cnt_r   <= '0;
            state_r <= S_ROT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_TRIG;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_TRIG: begin
          c_r     <= neg_r ? -cx : cx;
          s_r     <= neg_r ? -sx_t : sx_t;
          j_r     <= '0;
          state_r <= S_DLOAD;
        end
        S_DLOAD: begin
          quo_r   <= {mag[20:0], 10'b0};
          rem_r   <= '0;
          dneg_r  <= (num < 0);
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == 5'd30) begin
            unique case (j_r)
              2'd0:    ca_r <= coeff_res;
              2'd1:    cb_r <= coeff_res;
              2'd2:    cc_r <= coeff_res;
              default: cd_r <= coeff_res;
            endcase
            if (j_r == 2'd3) begin
              k_r     <= '0;
              ph_r    <= 1'b0;
              state_r <= S_MUL;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_DLOAD;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MUL: begin
          if (!ph_r) begin
            prod_r <= prod;
            ph_r   <= 1'b1;
          end else begin
            acc_r <= sum;
            ph_r  <= 1'b0;
            k_r   <= k_r + 4'd1;
            unique case (k_r)
              4'd1: off1_r <= sum[47:8];
              4'd3: off2_r <= sum[47:8];
              4'd5: er_r   <= sum[33:20];
              4'd7: ec_r   <= sum[33:20];
              4'd8: begin
                sat_r      <= (msz > 22'(MAX_MAP));
                map_rows_r <= (msz > 22'(MAX_MAP)) ? 14'(MAX_MAP) : msz[13:0];
              end
              4'd9: begin
                sat_r      <= sat_r || (msz > 22'(MAX_MAP));
                map_cols_r <= (msz > 22'(MAX_MAP)) ? 14'(MAX_MAP) : msz[13:0];
                state_r    <= S_IDLE;
              end
              default: ;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);

  assign dv.coeff_a    = ca_r;
  assign dv.coeff_b    = cb_r;
  assign dv.coeff_c    = cc_r;
  assign dv.coeff_d    = cd_r;
  assign dv.off_first  = off1_r;
  assign dv.off_second = off2_r;
  assign dv.size_rows  = map_rows_r;
  assign dv.size_cols  = map_cols_r;
  assign dv.size_sat   = sat_r;
  assign dv.half_rows  = rows_r[12:1];
  assign dv.half_cols  = cols_r[12:1];

endmodule

### hdl/rst_inverse_map_coordinate_generator.sv
// Inverse rotate-scale-translate coordinate generator for a remap engine.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// angle, scales, translations and source size. Each write starts a
// recomputation of the mapping coefficients and map size (angle folding,
// a 30-step CORDIC, four serial divisions and ten multiply steps on one
// shared multiplier). cfg_ready and in_ready stay low meanwhile; an unknown
// register index is taken and ignored.
// Pixel channel: one destination pixel (row, column) per beat in, one
// coordinate result per beat out. Three-stage pipeline (input, products,
// sums and rounding); the valid flag passes v1_r, v2_r and out_valid_r, and
// a new pixel is accepted every cycle unless the receiver stalls or busy is high.
// When the receiver stalls, the whole pipeline holds and in_ready falls
// in the same cycle; no beat is lost.
// Reset loads the default register values and clears the derived state, so
// until the first write every pixel is flagged outside the map.
module rst_inverse_map_coordinate_generator
  import rstim_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        in_dest_row,
  input  logic [13:0]        in_dest_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_map1_coord,
  output logic signed [31:0] out_map2_coord,
  output logic [13:0]        out_map_row_count,
  output logic [13:0]        out_map_col_count,
  output logic               out_outside_map,
  output logic               out_size_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  derived_t dv;
  logic     busy;
  logic     adv;

  logic               v1_r, v2_r, out_valid_r;
  logic signed [14:0] u1_r, w1_r;
  logic               outside1_r, outside2_r, outside_r;
  logic signed [46:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [31:0] map1_r, map2_r;

  logic signed [14:0] u_in, w_in;
  logic signed [49:0] half_r, half_c, o1, o2, m1, m2;

  function automatic logic signed [31:0] to_out(input logic signed [49:0] m);
    logic signed [49:0] t;
    logic signed [31:0] o;
    t = (m + (50'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (t > 50'sd2147483647) o = 32'sh7FFFFFFF;
    else if (t < -50'sd2147483648) o = 32'sh80000000;
    else o = t[31:0];
    return o;
  endfunction

  rstim_derive u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .dv        (dv)
  );

  // advance all stages unless the output beat is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !busy;

  assign u_in = $signed({1'b0, in_dest_row}) - $signed({2'b0, dv.size_rows[13:1]});
  assign w_in = $signed({2'b0, dv.size_cols[13:1]}) - $signed({1'b0, in_dest_col});

  assign half_r = $signed({16'b0, dv.half_rows, 22'b0});
  assign half_c = $signed({16'b0, dv.half_cols, 22'b0});
  assign o1     = 50'($signed(dv.off_first)) <<< 4;
  assign o2     = 50'($signed(dv.off_second)) <<< 4;
  assign m1     = 50'(pa_r) + 50'(pb_r) + o1 + half_r;
  assign m2     = half_c - (50'(pc_r) + 50'(pd_r) + o2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid && in_ready;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_r       <= u_in;
      w1_r       <= w_in;
      outside1_r <= (in_dest_row >= dv.size_rows) || (in_dest_col >= dv.size_cols);
      pa_r       <= $signed(dv.coeff_a) * u1_r;
      pb_r       <= $signed(dv.coeff_b) * w1_r;
      pc_r       <= $signed(dv.coeff_c) * u1_r;
      pd_r       <= $signed(dv.coeff_d) * w1_r;
      outside2_r <= outside1_r;
      map1_r     <= to_out(m1);
      map2_r     <= to_out(m2);
      outside_r  <= outside2_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_map1_coord     = map1_r;
  assign out_map2_coord     = map2_r;
  assign out_map_row_count  = dv.size_rows;
  assign out_map_col_count  = dv.size_cols;
  assign out_outside_map    = outside_r;
  assign out_size_saturated = dv.size_sat;

endmodule

### bench/rst_inverse_map_coordinate_generator_tb.sv
module rst_inverse_map_coordinate_generator_tb;
  import rstim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int NUM_REGS   = 7;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic signed [31:0] map1;
    logic signed [31:0] map2;
    logic [13:0]        row_count;
    logic [13:0]        col_count;
    logic               outside;
    logic               saturated;
  } coord_result_t;

  class coord_scoreboard;
    longint        regs[NUM_REGS];
    longint        ca, cb, cc, cd, off1, off2;
    longint        rows_map, cols_map;
    bit            sat;
    coord_result_t pending[$];
    int            mismatches;
    int            checked;
    int            outside_seen;
    int            saturated_seen;
    longint        arctan[CORDIC_STEPS];

    function new();
      arctan = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
      regs = '{0, 256, 256, 0, 0, 512, 512};
      ca = 0; cb = 0; cc = 0; cd = 0; off1 = 0; off2 = 0;
      rows_map = 0; cols_map = 0; sat = 0;
      mismatches = 0; checked = 0; outside_seen = 0; saturated_seen = 0;
    endfunction

    function longint unit_clamp(longint v);
      if (v > (64'sd1 << 20)) return 64'sd1 << 20;
      if (v < -(64'sd1 << 20)) return -(64'sd1 << 20);
      return v;
    endfunction

    function void rederive();
      longint z, x, y, dx, dy, c, s, ac, as_, sx, sy, tx, ty, er, ec, mr, mc;
      logic [16:0] ang;
      bit flip;
      ang = regs[0][16:0];
      z = longint'($signed(ang)) * 131072;
      x = longint'(CORDIC_GAIN);
      y = 0;
      flip = 0;
      for (int i = 0; i < 4; i++) begin
        if (z > longint'(HALF_PI_Q30)) begin
          z -= longint'(PI_Q30); flip = !flip;
        end else if (z < -longint'(HALF_PI_Q30)) begin
          z += longint'(PI_Q30); flip = !flip;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan[i];
        end else begin
          x += dx; y -= dy; z += arctan[i];
        end
      end
      c = unit_clamp((x + 512) >>> 10);
      s = unit_clamp((y + 512) >>> 10);
      if (flip) begin
        c = -c; s = -s;
      end
      sx = (regs[1] == 0) ? 1 : regs[1];
      sy = (regs[2] == 0) ? 1 : regs[2];
      ca = (c * 1024) / sx;
      cb = (s * 1024) / sy;
      cc = (-s * 1024) / sx;
      cd = (c * 1024) / sy;
      tx = longint'($signed(regs[3][15:0]));
      ty = longint'($signed(regs[4][15:0]));
      off1 = (ca * ty + cb * tx) >>> 8;
      off2 = (cc * ty + cd * tx) >>> 8;
      ac = (c < 0) ? -c : c;
      as_ = (s < 0) ? -s : s;
      er = (regs[6] * as_ + regs[5] * ac) >> 20;
      ec = (regs[6] * ac + regs[5] * as_) >> 20;
      mr = (sx * er) >> 8;
      mc = (sy * ec) >> 8;
      sat = (mr > MAX_MAP) || (mc > MAX_MAP);
      rows_map = (mr > MAX_MAP) ? MAX_MAP : mr;
      cols_map = (mc > MAX_MAP) ? MAX_MAP : mc;
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] data);
      int w;
      if (idx > REG_SOURCE_COLS) return;
      w = (idx == REG_ROT_ANGLE) ? 17 :
          (idx == REG_SOURCE_ROWS || idx == REG_SOURCE_COLS) ? 13 : 16;
      regs[idx] = longint'(data) & ((64'sd1 << w) - 1);
      rederive();
    endfunction

    function logic signed [31:0] to_q8(longint q22);
      longint v;
      v = (q22 + (64'sd1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_pixel(logic [13:0] row, logic [13:0] col);
      longint u, v, m1, m2;
      coord_result_t e;
      u = longint'(row) - rows_map / 2;
      v = cols_map / 2 - longint'(col);
      m1 = ca * u + cb * v + off1 * 16 + ((regs[5] / 2) << COEF_FRAC);
      m2 = ((regs[6] / 2) << COEF_FRAC) - (cc * u + cd * v + off2 * 16);
      e.map1 = to_q8(m1);
      e.map2 = to_q8(m2);
      e.row_count = rows_map[13:0];
      e.col_count = cols_map[13:0];
      e.outside = (longint'(row) >= rows_map) || (longint'(col) >= cols_map);
      e.saturated = sat;
      pending.push_back(e);
    endfunction

    function void check_result(coord_result_t got);
      coord_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat map1=%0d map2=%0d",
                                       got.map1, got.map2);
        return;
      end
      e = pending.pop_front();
      checked++;
      outside_seen += e.outside;
      saturated_seen += e.saturated;
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch #%0d: exp m1=%0d m2=%0d rc=%0d cc=%0d out=%0b sat=%0b",
                    " | got m1=%0d m2=%0d rc=%0d cc=%0d out=%0b sat=%0b"},
                   checked, e.map1, e.map2, e.row_count, e.col_count, e.outside,
                   e.saturated, got.map1, got.map2, got.row_count, got.col_count,
                   got.outside, got.saturated);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [13:0]        in_dest_row = '0;
  logic [13:0]        in_dest_col = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_map1_coord;
  logic signed [31:0] out_map2_coord;
  logic [13:0]        out_map_row_count;
  logic [13:0]        out_map_col_count;
  logic               out_outside_map;
  logic               out_size_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  coord_scoreboard sb = new();
  int              cycles = 0;
  int              phases = 0;
  int              stall_pct = 0;

  rst_inverse_map_coordinate_generator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: stall density is redrawn per window, some windows never stall
  always @(posedge clk) begin
    if (cycles % 256 == 0)
      stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_map1_coord, out_map2_coord, out_map_row_count,
                        out_map_col_count, out_outside_map, out_size_saturated});
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [16:0] v[NUM_REGS]);
    drain();
    for (int i = 0; i < NUM_REGS; i++) write_cfg(3'(i), v[i]);
    phases++;
  endtask

  // hold valid across back-to-back beats; lower it only when a gap follows
  task automatic send_pixel(logic [13:0] row, logic [13:0] col);
    in_valid    <= 1'b1;
    in_dest_row <= row;
    in_dest_col <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(row, col);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [13:0] pick_coord(longint lim);
    if (lim == 0 || $urandom_range(0, 99) < 15) return 14'($urandom);
    return 14'($urandom_range(0, (lim + 2 > 16383) ? 16383 : int'(lim + 2)));
  endfunction

  task automatic random_pixels(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n > 0; k++, n--)
        send_pixel(pick_coord(sb.rows_map), pick_coord(sb.cols_map));
      idle_gap();
    end
    in_valid <= 1'b0;
  endtask

  task automatic edge_pixels();
    logic [13:0] r, c;
    r = sb.rows_map[13:0];
    c = sb.cols_map[13:0];
    send_pixel(14'd0, 14'd0);
    send_pixel(r - 14'd1, c - 14'd1);
    send_pixel(r, 14'd0);
    send_pixel(14'd0, c);
    send_pixel(14'h3FFF, 14'h3FFF);
    in_valid <= 1'b0;
  endtask

  logic [16:0] cfg_set[NUM_REGS];

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing written yet: all pixels outside, coordinates sit at the source centre
    send_pixel(14'd0, 14'd0);
    send_pixel(14'h3FFF, 14'h3FFF);
    send_pixel(14'h2AAA, 14'h1555);
    in_valid <= 1'b0;

    cfg_set = '{17'd0, 17'd256, 17'd256, 17'd0, 17'd0, 17'd512, 17'd512};
    write_all(cfg_set);
    edge_pixels();
    // angle near -2 pi, largest scales, sizes of 4096: map clips at its limit
    cfg_set = '{-17'sd51472, 17'hFFFF, 17'hFFFF, 17'h7FFF, 17'h8000, 17'd4096, 17'd4096};
    write_all(cfg_set);
    edge_pixels();
    // zero scales act as one, sizes of one, upper data bits discarded
    cfg_set = '{17'd51472, 17'h10000, 17'h10000, 17'h18000, 17'h17FFF, 17'd1, 17'd1};
    write_all(cfg_set);
    edge_pixels();
    // angle near -8 rad and +8 rad, unknown index ignored
    cfg_set = '{17'h10000, 17'd300, 17'd200, 17'h0123, 17'hFEDC, 17'd4095, 17'd100};
    write_all(cfg_set);
    write_cfg(REG_UNUSED, 17'h1FFFF);
    edge_pixels();
    drain();
    write_cfg(REG_ROT_ANGLE, 17'h0FFFF);
    edge_pixels();

    for (int p = 0; p < 11; p++) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = 17'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        cfg_set[1] = 17'($urandom_range(64, 1024));
        cfg_set[2] = 17'($urandom_range(64, 1024));
        cfg_set[5] = 17'($urandom_range(1, 600));
        cfg_set[6] = 17'($urandom_range(1, 600));
      end
      write_all(cfg_set);
      if (p % 3 == 0) write_cfg(REG_UNUSED, 17'($urandom));
      random_pixels(110);
      drain();
      write_cfg(3'($urandom_range(0, NUM_REGS - 1)), 17'($urandom));
      random_pixels($urandom_range(0, 1) ? 0 : 20);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d coordinate beats over %0d register settings", sb.checked, phases);
    $display("%0d flagged outside the map, %0d with a clipped map size",
             sb.outside_seen, sb.saturated_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/rstim_pkg.sv
hdl/rstim_derive.sv
hdl/rst_inverse_map_coordinate_generator.sv
bench/rst_inverse_map_coordinate_generator_tb.sv
